// ===== rtl/core/bwc5_pkg.sv =====
package bwc5_pkg;

	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int SIZE_W          = 12;
	localparam int THR_W           = 5;
	localparam int POS_W           = 11;
	localparam int CNT_W           = 5;
	localparam int WIN             = 5;
	localparam int HALF_WIN        = 2;
	localparam int MIN_SIZE        = 5;
	localparam int RESET_SIZE      = 2048;
	localparam int RESET_THRESHOLD = 13;
	localparam int LINE_W          = WIN - 1;
	localparam int COL_CNT_W       = 3;
	localparam int CFG_IDX_W       = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_SIZE      = 1'b0,
		CFG_COUNT_THRESHOLD = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic pixel_on;
	} pix_t;

	typedef struct packed {
		logic [POS_W-1:0] center_row;
		logic [POS_W-1:0] center_col;
		logic [CNT_W-1:0] window_count;
		logic             dense;
		logic             last_of_frame;
	} res_t;

	// control shared by every cell of the window chain
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic logic [COL_CNT_W-1:0] ones5(input logic [WIN-1:0] v);
		logic [COL_CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WIN; i++) begin
			n = n + COL_CNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/bwc5_stream_if.sv =====
interface bwc5_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bwc5_ram.sv =====
module bwc5_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/bwc5_cell.sv =====
module bwc5_cell import bwc5_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [WIN-1:0]       col_in,
	output logic [WIN-1:0]       col_q,
	output logic [COL_CNT_W-1:0] cnt_q
);
	// hold one window column and its set-bit count; pass the column on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.clear) begin
			col_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= col_in;
			cnt_q <= ones5(col_in);
		end
	end
endmodule

// ===== rtl/core/binary_window_count_5x5_top.sv =====
// 5x5 binary window count.
// Channels: pix (sink) takes one pixel_on beat per pixel of a square image in
// raster order; res (source) gives one beat per interior center (two or more
// pixels from every edge) with its row, column, set-pixel count, the dense
// flag (count >= count_threshold) and last_of_frame on the final center.
// Configuration: cfg_we/cfg_index/cfg_data write image_size (index 0) or
// count_threshold (index 1). Writing image_size restarts the frame.
// Path: an accepted pixel waits in stage one for its line-store read; its
// result is then registered in the output register when stage one advances.
// Throughput: one pixel per cycle while no held-off result stalls stage one;
// set by the line store (read on acceptance, read-modify-write as stage one
// advances) and the five-cell window chain that shifts once per pixel.
// Reset: counters, window and output empty; image_size 2048 (clamped to
// MAX_WIDTH), count_threshold 13. The line store needs no clearing: its first
// four rows of every frame are flushed out before any result uses them.
// Stall: while res is held off, the finished result waits in the output
// register; pixels that give no result keep passing, and the next pixel that
// gives one waits in stage one and holds further pixels off.
module binary_window_count_5x5_top import bwc5_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bwc5_stream_if.sink          pix,
	bwc5_stream_if.source        res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int NW = CW + 1;

	// clamp the written side length into the supported range
	function automatic logic [NW-1:0] side_of(input logic [SIZE_W-1:0] s);
		if (int'(s) < MIN_SIZE) begin
			return NW'(MIN_SIZE);
		end
		if (int'(s) > MAX_WIDTH) begin
			return NW'(MAX_WIDTH);
		end
		return NW'(s);
	endfunction

	logic [NW-1:0]    side_q;
	logic [THR_W-1:0] thr_q;
	logic [CW-1:0]    row_q;
	logic [CW-1:0]    col_q;

	logic             valid_s1;
	logic             pix_s1;
	logic [CW-1:0]    row_s1;
	logic [CW-1:0]    col_s1;
	logic             produce_s1;
	logic             last_s1;

	logic             res_valid_q;
	res_t             res_q;

	logic             accept;
	logic             advance;
	logic             size_wr;
	logic             produce;
	logic             last;
	logic [NW-1:0]    col_next;
	logic [NW-1:0]    row_next;

	logic [LINE_W-1:0] above;
	logic [WIN-1:0]    new_col;
	cell_ctrl_t        cell_ctrl;
	logic [WIN-1:0]    cell_col [WIN+1];
	logic [COL_CNT_W-1:0] cell_cnt [WIN];
	logic [CNT_W-1:0]  count;
	logic [CW-1:0]     crow;
	logic [CW-1:0]     ccol;

	assign size_wr = cfg_we && (cfg_index == CFG_IMAGE_SIZE);

	// move stage one forward when its result has room, or when it has none
	assign advance = valid_s1 && (!produce_s1 || !res_valid_q || res.ready);
	assign pix.ready = !valid_s1 || advance;
	assign accept = pix.valid && pix.ready;

	assign produce  = (row_q >= CW'(2 * HALF_WIN)) && (col_q >= CW'(2 * HALF_WIN));
	assign col_next = {1'b0, col_q} + NW'(1);
	assign row_next = {1'b0, row_q} + NW'(1);
	assign last     = ({1'b0, row_q} == side_q - NW'(1))
		&& ({1'b0, col_q} == side_q - NW'(1));

	// configuration registers and raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= side_of(SIZE_W'(RESET_SIZE));
			thr_q  <= THR_W'(RESET_THRESHOLD);
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			if (cfg_we && (cfg_index == CFG_COUNT_THRESHOLD)) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (size_wr) begin
				side_q <= side_of(cfg_data);
				row_q  <= '0;
				col_q  <= '0;
			end else if (accept) begin
				if (col_next >= side_q) begin
					col_q <= '0;
					row_q <= (row_next >= side_q) ? '0 : row_next[CW-1:0];
				end else begin
					col_q <= col_next[CW-1:0];
				end
			end
		end
	end

	// stage one: wait for the line-store read of this column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix.payload.pixel_on;
			row_s1     <= row_q;
			col_s1     <= col_q;
			produce_s1 <= produce;
			last_s1    <= last;
		end
	end

	// line store: four rows above each column, oldest in the top bit
	bwc5_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (advance),
		.waddr (col_s1),
		.wdata ({above[LINE_W-2:0], pix_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (above)
	);

	assign new_col = {above, pix_s1};

	// window chain: cell 0 holds the newest column
	assign cell_ctrl.shift = advance;
	assign cell_ctrl.clear = size_wr;
	assign cell_col[0] = new_col;

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		bwc5_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.col_in (cell_col[k]),
			.col_q  (cell_col[k+1]),
			.cnt_q  (cell_cnt[k])
		);
	end

	// count of the window after this shift: the new column plus the four
	// columns that stay
	always_comb begin
		count = CNT_W'(ones5(new_col));
		for (int k = 0; k < WIN - 1; k++) begin
			count = count + CNT_W'(cell_cnt[k]);
		end
	end

	assign crow = row_s1 - CW'(HALF_WIN);
	assign ccol = col_s1 - CW'(HALF_WIN);

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produce_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce_s1) begin
			res_q.center_row    <= POS_W'(crow);
			res_q.center_col    <= POS_W'(ccol);
			res_q.window_count  <= count;
			res_q.dense         <= ({1'b0, count} >= {1'b0, thr_q});
			res_q.last_of_frame <= last_s1;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule

// ===== rtl/core/bwc5_check.sv =====
module bwc5_check import bwc5_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             pix_ready,
	input logic             res_valid,
	input logic             res_ready,
	input res_t             res_payload
);
	// a held-off result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("result changed while stalled");

	// with the output empty, the pixel side never stalls
	a_pix_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("pixel side stalled with empty output");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_payload.window_count <= CNT_W'(WIN * WIN))
		else $error("window count out of range");

	a_center_border: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_payload.center_row >= POS_W'(HALF_WIN)
			&& res_payload.center_col >= POS_W'(HALF_WIN))
		else $error("border center emitted");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.last_of_frame
			|-> res_payload.center_row == res_payload.center_col)
		else $error("last center off the diagonal");
endmodule

bind binary_window_count_5x5_top bwc5_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_ready   (pix.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);
